### hdl/pwhl_pkg.sv
package pwhl_pkg;

    // default structural sizes
    localparam int RING_DEPTH_DEF = 60;
    localparam int NUM_PHASES_DEF = 4;

    // field widths
    localparam int COUNT_W   = 16;
    localparam int ELAPSED_W = 16;
    localparam int WINDOW_W  = 10;
    localparam int THRESH_W  = 14;
    localparam int LEN_W     = 6;
    localparam int PCT_W     = 23;
    localparam int TRANS_W   = 2;
    localparam int PHASE_W   = 2;
    localparam int NUM_LEN   = 4;

    // event_count * window_ms
    localparam int PROD_W = COUNT_W + WINDOW_W;
    // sum of up to 63 percentages
    localparam int TOT_W  = PCT_W + LEN_W;
    // shared divider sizes: dividend covers both the product and the sum
    localparam int DIV_NW = TOT_W;
    localparam int DIV_DW = 20;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = THRESH_W;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN3   = 3'd5;

    // configuration reset values
    localparam logic [WINDOW_W-1:0] WINDOW_RST = 10'd500;
    localparam logic [THRESH_W-1:0] THRESH_RST = 14'd50;
    localparam logic [LEN_W-1:0]    LEN0_RST   = 6'd1;
    localparam logic [LEN_W-1:0]    LEN1_RST   = 6'd4;
    localparam logic [LEN_W-1:0]    LEN2_RST   = 6'd8;
    localparam logic [LEN_W-1:0]    LEN3_RST   = 6'd10;

    // transition codes
    localparam logic [TRANS_W-1:0] TR_NONE = 2'd0;
    localparam logic [TRANS_W-1:0] TR_SET  = 2'd1;
    localparam logic [TRANS_W-1:0] TR_REL  = 2'd2;

endpackage

### hdl/pwhl_ring.sv
module pwhl_ring #(
    parameter int DEPTH = pwhl_pkg::RING_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = pwhl_pkg::PCT_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DW-1:0] r_rdata;
    logic          r_rvld;

    // storage array, no reset
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // per-entry written flags, an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

### hdl/pwhl_div.sv
module pwhl_div #(
    parameter int NW = pwhl_pkg::DIV_NW,
    parameter int DW = pwhl_pkg::DIV_DW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvsr;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          qbit;

    // one restoring step: shift in next dividend bit, try subtract
    always_comb begin
        shifted = {r_rem, r_quo[NW-1]};
        diff    = shifted - {1'b0, r_dvsr};
        qbit    = (shifted >= {1'b0, r_dvsr});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], qbit};
            r_rem <= qbit ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### hdl/pressure_window_hysteresis_lock.sv
// the shared bit-serial divider runs twice per transaction (pressure, then average); between
// the two runs the ring is swept one entry per cycle over N entries, N = active phase length;
// when N is zero the sweep reads nothing and the second division is skipped
// one transaction at a time: a new one is taken only in idle, also while a result waits
// reset: synchronous active low; clears phase, lock, write pointer, ring written flags,
// output valid, and loads configuration defaults
module pressure_window_hysteresis_lock #(
    parameter int RING_DEPTH = pwhl_pkg::RING_DEPTH_DEF,
    parameter int NUM_PHASES = pwhl_pkg::NUM_PHASES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [pwhl_pkg::COUNT_W-1:0]        i_event_count,
    input  logic [pwhl_pkg::ELAPSED_W-1:0]      i_elapsed_seconds,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_pressure_lock,
    output logic [pwhl_pkg::TRANS_W-1:0]        o_transition,
    output logic [pwhl_pkg::PHASE_W-1:0]        o_phase_now,
    output logic [pwhl_pkg::PCT_W-1:0]          o_window_average,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pwhl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pwhl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int PW  = $clog2(NUM_PHASES);
    localparam int LIW = $clog2(pwhl_pkg::NUM_LEN);
    localparam logic [PW-1:0] PHASE_TOP = PW'(NUM_PHASES - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_DIV1  = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_DIV2  = 8'b0001_0000,
        S_DONE  = 8'b0010_0000,
        S_SPARE = 8'b0100_0000,
        S_HOLD  = 8'b1000_0000
    } t_state;

    // configuration
    logic [pwhl_pkg::WINDOW_W-1:0] r_window;
    logic [pwhl_pkg::THRESH_W-1:0] r_thresh;
    logic [pwhl_pkg::LEN_W-1:0]    r_len [pwhl_pkg::NUM_LEN];

    // control and datapath registers
    t_state                          r_state,     n_state;
    logic [pwhl_pkg::COUNT_W-1:0]    r_count,     n_count;
    logic [pwhl_pkg::ELAPSED_W-1:0]  r_elapsed,   n_elapsed;
    logic [pwhl_pkg::PROD_W-1:0]     r_prod,      n_prod;
    logic [pwhl_pkg::DIV_DW-1:0]     r_dvsr,      n_dvsr;
    logic [pwhl_pkg::LEN_W-1:0]      r_n,         n_n;
    logic [pwhl_pkg::LEN_W-1:0]      r_left,      n_left;
    logic [pwhl_pkg::TOT_W-1:0]      r_total,     n_total;
    logic [pwhl_pkg::PCT_W-1:0]      r_avg,       n_avg;
    logic [AW-1:0]                   r_wp,        n_wp;
    logic [AW-1:0]                   r_rd_pos,    n_rd_pos;
    logic                            r_pend,      n_pend;
    logic                            r_go,        n_go;
    logic [PW-1:0]                   r_phase,     n_phase;
    logic                            r_lock,      n_lock;
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_hp,    n_out_hp;
    logic [pwhl_pkg::TRANS_W-1:0]    r_out_tr,    n_out_tr;
    logic [pwhl_pkg::PHASE_W-1:0]    r_out_ph,    n_out_ph;
    logic [pwhl_pkg::PCT_W-1:0]      r_out_avg,   n_out_avg;

    // sub-unit hookup
    logic                            ring_we;
    logic                            ring_re;
    logic [pwhl_pkg::PCT_W-1:0]      ring_rdata;
    logic                            div_done;
    logic [pwhl_pkg::DIV_NW-1:0]     div_quot;
    logic [pwhl_pkg::DIV_NW-1:0]     div_dividend;
    logic [pwhl_pkg::DIV_DW-1:0]     div_divisor;

    // phase update helpers
    logic [pwhl_pkg::LEN_W-1:0]      sel_len;
    logic                            step_up;
    logic [PW-1:0]                   upd_phase;
    logic                            upd_lock;
    logic [pwhl_pkg::TRANS_W-1:0]    upd_tr;
    logic                            out_free;

    // configuration writes, port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= pwhl_pkg::WINDOW_RST;
            r_thresh <= pwhl_pkg::THRESH_RST;
            r_len[0] <= pwhl_pkg::LEN0_RST;
            r_len[1] <= pwhl_pkg::LEN1_RST;
            r_len[2] <= pwhl_pkg::LEN2_RST;
            r_len[3] <= pwhl_pkg::LEN3_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pwhl_pkg::CFG_WINDOW: r_window <= i_cfg_data[pwhl_pkg::WINDOW_W-1:0];
                pwhl_pkg::CFG_THRESH: r_thresh <= i_cfg_data;
                pwhl_pkg::CFG_LEN0:   r_len[0] <= i_cfg_data[pwhl_pkg::LEN_W-1:0];
                pwhl_pkg::CFG_LEN1:   r_len[1] <= i_cfg_data[pwhl_pkg::LEN_W-1:0];
                pwhl_pkg::CFG_LEN2:   r_len[2] <= i_cfg_data[pwhl_pkg::LEN_W-1:0];
                pwhl_pkg::CFG_LEN3:   r_len[3] <= i_cfg_data[pwhl_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // phase length lookup, phases past the last register share it
    always_comb begin
        sel_len = r_len[pwhl_pkg::NUM_LEN-1];
        for (int i = 0; i < pwhl_pkg::NUM_LEN - 1; i++) begin
            if (int'(r_phase) == i) begin
                sel_len = r_len[LIW'(i)];
            end
        end
    end

    // hysteresis step with clamping at both ends
    always_comb begin
        step_up   = ({(pwhl_pkg::PCT_W - pwhl_pkg::THRESH_W)'(0), r_thresh} < r_avg);
        upd_phase = r_phase;
        upd_lock  = r_lock;
        upd_tr    = pwhl_pkg::TR_NONE;
        if (step_up) begin
            if (int'(r_phase) + 1 >= NUM_PHASES - 1) begin
                upd_phase = PHASE_TOP;
                if (!r_lock) begin
                    upd_lock = 1'b1;
                    upd_tr   = pwhl_pkg::TR_SET;
                end
            end else begin
                upd_phase = r_phase + 1'b1;
            end
        end else begin
            if (r_phase == '0) begin
                if (r_lock) begin
                    upd_lock = 1'b0;
                    upd_tr   = pwhl_pkg::TR_REL;
                end
            end else begin
                upd_phase = r_phase - 1'b1;
            end
        end
    end

    // shared divider operands: pressure first, then the window average
    assign div_dividend = (r_state == S_DIV2) ? r_total
                                              : pwhl_pkg::DIV_NW'(r_prod);
    assign div_divisor  = (r_state == S_DIV2) ? pwhl_pkg::DIV_DW'(r_n) : r_dvsr;

    assign ring_we  = (r_state == S_DIV1) && div_done;
    assign ring_re  = (r_state == S_READ) && (r_left != '0);
    assign out_free = !r_out_valid || !i_out_stall;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_elapsed   = r_elapsed;
        n_prod      = r_prod;
        n_dvsr      = r_dvsr;
        n_n         = r_n;
        n_left      = r_left;
        n_total     = r_total;
        n_avg       = r_avg;
        n_wp        = r_wp;
        n_rd_pos    = r_rd_pos;
        n_pend      = 1'b0;
        n_go        = 1'b0;
        n_phase     = r_phase;
        n_lock      = r_lock;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_hp    = r_out_hp;
        n_out_tr    = r_out_tr;
        n_out_ph    = r_out_ph;
        n_out_avg   = r_out_avg;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_count   = i_event_count;
                    n_elapsed = i_elapsed_seconds;
                    n_state   = S_MUL;
                end
            end
            S_MUL: begin
                // percent = count*window*100 / (elapsed*1000) = count*window / (10*elapsed)
                n_prod = pwhl_pkg::PROD_W'(r_count) * pwhl_pkg::PROD_W'(r_window);
                if (r_elapsed == '0) begin
                    n_dvsr = pwhl_pkg::DIV_DW'(10);
                end else begin
                    n_dvsr = (pwhl_pkg::DIV_DW'(r_elapsed) << 3)
                           + (pwhl_pkg::DIV_DW'(r_elapsed) << 1);
                end
                n_n     = sel_len;
                n_go    = 1'b1;
                n_state = S_DIV1;
            end
            S_DIV1: begin
                if (div_done) begin
                    n_wp     = (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                    n_rd_pos = r_wp;
                    n_left   = r_n;
                    n_total  = '0;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                // read issued one cycle, accumulated the next
                if (r_pend) begin
                    n_total = r_total + pwhl_pkg::TOT_W'(ring_rdata);
                end
                if (r_left != '0) begin
                    n_rd_pos = (r_rd_pos == '0) ? AW'(RING_DEPTH - 1) : r_rd_pos - 1'b1;
                    n_left   = r_left - 1'b1;
                    n_pend   = 1'b1;
                end else if (!r_pend) begin
                    if (r_n == '0) begin
                        n_avg   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_go    = 1'b1;
                        n_state = S_DIV2;
                    end
                end
            end
            S_DIV2: begin
                // a total below N divides to zero by itself
                if (div_done) begin
                    n_avg   = div_quot[pwhl_pkg::PCT_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_phase     = upd_phase;
                    n_lock      = upd_lock;
                    n_out_valid = 1'b1;
                    n_out_hp    = upd_lock;
                    n_out_tr    = upd_tr;
                    n_out_ph    = pwhl_pkg::PHASE_W'(upd_phase);
                    n_out_avg   = r_avg;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_pend      <= 1'b0;
            r_go        <= 1'b0;
            r_phase     <= '0;
            r_lock      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_pend      <= n_pend;
            r_go        <= n_go;
            r_phase     <= n_phase;
            r_lock      <= n_lock;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_count   <= n_count;
        r_elapsed <= n_elapsed;
        r_prod    <= n_prod;
        r_dvsr    <= n_dvsr;
        r_n       <= n_n;
        r_left    <= n_left;
        r_total   <= n_total;
        r_avg     <= n_avg;
        r_rd_pos  <= n_rd_pos;
        r_out_hp  <= n_out_hp;
        r_out_tr  <= n_out_tr;
        r_out_ph  <= n_out_ph;
        r_out_avg <= n_out_avg;
    end

    pwhl_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW),
        .DW    (pwhl_pkg::PCT_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (ring_we),
        .i_waddr (r_wp),
        .i_wdata (div_quot[pwhl_pkg::PCT_W-1:0]),
        .i_re    (ring_re),
        .i_raddr (r_rd_pos),
        .o_rdata (ring_rdata)
    );

    pwhl_div #(
        .NW (pwhl_pkg::DIV_NW),
        .DW (pwhl_pkg::DIV_DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_go),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_pressure_lock  = r_out_hp;
    assign o_transition     = r_out_tr;
    assign o_phase_now      = r_out_ph;
    assign o_window_average = r_out_avg;

    // lock set only together with the lock flag high
    a_set_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_transition == pwhl_pkg::TR_SET) |-> o_pressure_lock)
        else $error("lock set reported without lock");

    // release only from phase zero with lock cleared
    a_rel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_transition == pwhl_pkg::TR_REL)
            |-> (!o_pressure_lock && o_phase_now == '0))
        else $error("release reported off phase zero");

    // ring write and sweep read never share a cycle
    a_ring_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ring_we && ring_re))
        else $error("ring write overlaps read");

    // finishing transaction always lands in the output register
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not loaded");

endmodule
